// ===== rtl/core/cpu_6502_execute_unit_macros.svh =====
// assertion macros for the 6502 execute unit
`ifndef CPU_6502_EXECUTE_UNIT_MACROS_SVH
`define CPU_6502_EXECUTE_UNIT_MACROS_SVH

// property must hold at every clock edge out of reset
`define CPU6502_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression must never be true out of reset
`define CPU6502_NEVER(label, expr, msg) \
  `CPU6502_ASSERT(label, !(expr), msg)

`endif

// ===== rtl/core/cpu6502_pkg.sv =====
// types and constants shared by the 6502 execute unit
package cpu6502_pkg;

  typedef struct packed {
    logic [5:0] req_type;
    logic [7:0] operand;
  } req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       write_enable;
    logic [8:0] stack_addr;
    logic       branch_taken;
    logic [7:0] status;
  } rsp_t;

  localparam logic [5:0] OP_ORA   = 6'd0;
  localparam logic [5:0] OP_AND   = 6'd1;
  localparam logic [5:0] OP_EOR   = 6'd2;
  localparam logic [5:0] OP_ADC   = 6'd3;
  localparam logic [5:0] OP_SBC   = 6'd4;
  localparam logic [5:0] OP_CMP   = 6'd5;
  localparam logic [5:0] OP_CPX   = 6'd6;
  localparam logic [5:0] OP_CPY   = 6'd7;
  localparam logic [5:0] OP_LDA   = 6'd8;
  localparam logic [5:0] OP_LDX   = 6'd9;
  localparam logic [5:0] OP_LDY   = 6'd10;
  localparam logic [5:0] OP_STA   = 6'd11;
  localparam logic [5:0] OP_STX   = 6'd12;
  localparam logic [5:0] OP_STY   = 6'd13;
  localparam logic [5:0] OP_BIT   = 6'd14;
  localparam logic [5:0] OP_ASL_A = 6'd15;
  localparam logic [5:0] OP_ROL_A = 6'd16;
  localparam logic [5:0] OP_LSR_A = 6'd17;
  localparam logic [5:0] OP_ROR_A = 6'd18;
  localparam logic [5:0] OP_ASL_M = 6'd19;
  localparam logic [5:0] OP_ROL_M = 6'd20;
  localparam logic [5:0] OP_LSR_M = 6'd21;
  localparam logic [5:0] OP_ROR_M = 6'd22;
  localparam logic [5:0] OP_INC_M = 6'd23;
  localparam logic [5:0] OP_DEC_M = 6'd24;
  localparam logic [5:0] OP_INX   = 6'd25;
  localparam logic [5:0] OP_INY   = 6'd26;
  localparam logic [5:0] OP_DEX   = 6'd27;
  localparam logic [5:0] OP_DEY   = 6'd28;
  localparam logic [5:0] OP_TAX   = 6'd29;
  localparam logic [5:0] OP_TAY   = 6'd30;
  localparam logic [5:0] OP_TXA   = 6'd31;
  localparam logic [5:0] OP_TYA   = 6'd32;
  localparam logic [5:0] OP_TSX   = 6'd33;
  localparam logic [5:0] OP_TXS   = 6'd34;
  localparam logic [5:0] OP_CLC   = 6'd35;
  localparam logic [5:0] OP_SEC   = 6'd36;
  localparam logic [5:0] OP_CLI   = 6'd37;
  localparam logic [5:0] OP_SEI   = 6'd38;
  localparam logic [5:0] OP_CLD   = 6'd39;
  localparam logic [5:0] OP_SED   = 6'd40;
  localparam logic [5:0] OP_CLV   = 6'd41;
  localparam logic [5:0] OP_PHA   = 6'd42;
  localparam logic [5:0] OP_PHP   = 6'd43;
  localparam logic [5:0] OP_PLA   = 6'd44;
  localparam logic [5:0] OP_PLP   = 6'd45;
  localparam logic [5:0] OP_BRT   = 6'd46;
  localparam logic [5:0] OP_NOP   = 6'd47;

  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_I = 2;
  localparam int unsigned FLAG_D = 3;
  localparam int unsigned FLAG_B = 4;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

  localparam logic [1:0] COND_N = 2'd0;
  localparam logic [1:0] COND_V = 2'd1;
  localparam logic [1:0] COND_C = 2'd2;
  localparam logic [1:0] COND_Z = 2'd3;

  localparam logic [7:0] SP_RESET   = 8'hfd;
  localparam logic       STACK_PAGE = 1'b1;

endpackage

// ===== rtl/core/cpu_6502_execute_unit.sv =====
// 6502 execute stage: register file, alu, shifter and flag logic
//
// input channel: in_valid_i / in_stall_o with in_data_i carrying the
// operation code and the already fetched operand byte
// output channel: out_valid_o / out_stall_i with out_data_o carrying the
// byte to write, write strobe, stack address, branch decision and flags
// an item is transferred at a clock edge with valid high and stall low
// an accepted item is held in the input register, its result is computed from
// it and captured in the result register, which then drives the output
// throughput: one item per cycle while the receiver does not stall; every
// operation is at most a single 8-bit add, logic or shift on the registers,
// done between the two registers
// when the receiver stalls the result register holds, the input register
// fills behind it and in_stall_o rises once both are occupied
// reset clears a, x, y and the flags, sets the stack pointer to 0xfd and
// empties both pipeline registers
module cpu_6502_execute_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cpu6502_pkg::req_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cpu6502_pkg::rsp_t  out_data_o
);
  import cpu6502_pkg::*;

  logic       s1_valid_q;
  req_t       s1_q;
  logic       s2_valid_q;
  rsp_t       s2_q;
  logic       s1_ready;
  logic       s2_ready;
  logic       s1_fire;

  logic [7:0] a_q, a_d;
  logic [7:0] x_q, x_d;
  logic [7:0] y_q, y_d;
  logic [7:0] sp_q, sp_d;
  logic [7:0] p_q, p_d;

  logic [5:0] op;
  logic [7:0] opnd;

  logic [7:0] add_a;
  logic [7:0] add_b;
  logic       add_cin;
  logic [8:0] add_sum;
  logic       add_v;

  logic [7:0] sh_src;
  logic [7:0] sh_res;
  logic       sh_c;

  logic       cond_bit;
  logic [7:0] inc_res;
  logic [7:0] dec_res;

  logic       nz_upd;
  logic [7:0] nz_val;
  rsp_t       rsp;

  assign s2_ready = !s2_valid_q || !out_stall_i;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign s1_fire  = s1_valid_q && s2_ready;
  assign in_stall_o = !s1_ready;

  assign op   = s1_q.req_type;
  assign opnd = s1_q.operand;

  // adder shared by adc, sbc and the compares
  always_comb begin
    add_a   = a_q;
    add_b   = ~opnd;
    add_cin = 1'b1;
    case (op)
      OP_ADC: begin
        add_b   = opnd;
        add_cin = p_q[FLAG_C];
      end
      OP_SBC: add_cin = p_q[FLAG_C];
      OP_CPX: add_a = x_q;
      OP_CPY: add_a = y_q;
      default: ;
    endcase
    add_sum = {1'b0, add_a} + {1'b0, add_b} + {8'd0, add_cin};
    add_v   = (add_a[7] ^ add_sum[7]) & (add_b[7] ^ add_sum[7]);
  end

  // shifter for accumulator and memory forms
  always_comb begin
    sh_src = (op inside {OP_ASL_M, OP_ROL_M, OP_LSR_M, OP_ROR_M}) ? opnd : a_q;
    case (op)
      OP_ASL_A, OP_ASL_M: begin
        sh_res = {sh_src[6:0], 1'b0};
        sh_c   = sh_src[7];
      end
      OP_ROL_A, OP_ROL_M: begin
        sh_res = {sh_src[6:0], p_q[FLAG_C]};
        sh_c   = sh_src[7];
      end
      OP_LSR_A, OP_LSR_M: begin
        sh_res = {1'b0, sh_src[7:1]};
        sh_c   = sh_src[0];
      end
      OP_ROR_A, OP_ROR_M: begin
        sh_res = {p_q[FLAG_C], sh_src[7:1]};
        sh_c   = sh_src[0];
      end
      default: begin
        sh_res = sh_src;
        sh_c   = p_q[FLAG_C];
      end
    endcase
  end

  // branch condition select
  always_comb begin
    case (opnd[2:1])
      COND_N:  cond_bit = p_q[FLAG_N];
      COND_V:  cond_bit = p_q[FLAG_V];
      COND_C:  cond_bit = p_q[FLAG_C];
      COND_Z:  cond_bit = p_q[FLAG_Z];
      default: cond_bit = 1'b0;
    endcase
  end

  assign inc_res = opnd + 8'd1;
  assign dec_res = opnd - 8'd1;

  always_comb begin
    a_d    = a_q;
    x_d    = x_q;
    y_d    = y_q;
    sp_d   = sp_q;
    p_d    = p_q;
    nz_upd = 1'b0;
    nz_val = 8'd0;
    rsp.out_byte     = 8'd0;
    rsp.write_enable = 1'b0;
    rsp.stack_addr   = {STACK_PAGE, sp_q};
    rsp.branch_taken = 1'b0;
    case (op)
      OP_ORA: begin
        a_d = a_q | opnd; nz_upd = 1'b1; nz_val = a_d;
      end
      OP_AND: begin
        a_d = a_q & opnd; nz_upd = 1'b1; nz_val = a_d;
      end
      OP_EOR: begin
        a_d = a_q ^ opnd; nz_upd = 1'b1; nz_val = a_d;
      end
      OP_ADC, OP_SBC: begin
        a_d         = add_sum[7:0];
        p_d[FLAG_C] = add_sum[8];
        p_d[FLAG_V] = add_v;
        nz_upd      = 1'b1;
        nz_val      = add_sum[7:0];
      end
      OP_CMP, OP_CPX, OP_CPY: begin
        p_d[FLAG_C] = add_sum[8];
        nz_upd      = 1'b1;
        nz_val      = add_sum[7:0];
      end
      OP_LDA: begin
        a_d = opnd; nz_upd = 1'b1; nz_val = opnd;
      end
      OP_LDX: begin
        x_d = opnd; nz_upd = 1'b1; nz_val = opnd;
      end
      OP_LDY: begin
        y_d = opnd; nz_upd = 1'b1; nz_val = opnd;
      end
      OP_STA: begin
        rsp.out_byte = a_q; rsp.write_enable = 1'b1;
      end
      OP_STX: begin
        rsp.out_byte = x_q; rsp.write_enable = 1'b1;
      end
      OP_STY: begin
        rsp.out_byte = y_q; rsp.write_enable = 1'b1;
      end
      OP_BIT: begin
        p_d[FLAG_Z] = ((a_q & opnd) == 8'd0);
        p_d[FLAG_V] = opnd[6];
        p_d[FLAG_N] = opnd[7];
      end
      OP_ASL_A, OP_ROL_A, OP_LSR_A, OP_ROR_A: begin
        a_d         = sh_res;
        p_d[FLAG_C] = sh_c;
        nz_upd      = 1'b1;
        nz_val      = sh_res;
      end
      OP_ASL_M, OP_ROL_M, OP_LSR_M, OP_ROR_M: begin
        rsp.out_byte     = sh_res;
        rsp.write_enable = 1'b1;
        p_d[FLAG_C]      = sh_c;
        nz_upd           = 1'b1;
        nz_val           = sh_res;
      end
      OP_INC_M: begin
        rsp.out_byte = inc_res; rsp.write_enable = 1'b1;
        nz_upd = 1'b1; nz_val = inc_res;
      end
      OP_DEC_M: begin
        rsp.out_byte = dec_res; rsp.write_enable = 1'b1;
        nz_upd = 1'b1; nz_val = dec_res;
      end
      OP_INX: begin
        x_d = x_q + 8'd1; nz_upd = 1'b1; nz_val = x_d;
      end
      OP_INY: begin
        y_d = y_q + 8'd1; nz_upd = 1'b1; nz_val = y_d;
      end
      OP_DEX: begin
        x_d = x_q - 8'd1; nz_upd = 1'b1; nz_val = x_d;
      end
      OP_DEY: begin
        y_d = y_q - 8'd1; nz_upd = 1'b1; nz_val = y_d;
      end
      OP_TAX: begin
        x_d = a_q; nz_upd = 1'b1; nz_val = a_q;
      end
      OP_TAY: begin
        y_d = a_q; nz_upd = 1'b1; nz_val = a_q;
      end
      OP_TXA: begin
        a_d = x_q; nz_upd = 1'b1; nz_val = x_q;
      end
      OP_TYA: begin
        a_d = y_q; nz_upd = 1'b1; nz_val = y_q;
      end
      OP_TSX: begin
        x_d = sp_q; nz_upd = 1'b1; nz_val = sp_q;
      end
      OP_TXS: begin
        sp_d           = x_q;
        rsp.stack_addr = {STACK_PAGE, x_q};
      end
      OP_CLC: p_d[FLAG_C] = 1'b0;
      OP_SEC: p_d[FLAG_C] = 1'b1;
      OP_CLI: p_d[FLAG_I] = 1'b0;
      OP_SEI: p_d[FLAG_I] = 1'b1;
      OP_CLD: p_d[FLAG_D] = 1'b0;
      OP_SED: p_d[FLAG_D] = 1'b1;
      OP_CLV: p_d[FLAG_V] = 1'b0;
      OP_PHA, OP_PHP: begin
        rsp.out_byte     = (op == OP_PHA) ? a_q : p_q;
        rsp.write_enable = 1'b1;
        sp_d             = sp_q - 8'd1;
      end
      OP_PLA: begin
        sp_d           = sp_q + 8'd1;
        rsp.stack_addr = {STACK_PAGE, sp_d};
        a_d            = opnd;
        nz_upd         = 1'b1;
        nz_val         = opnd;
      end
      OP_PLP: begin
        sp_d           = sp_q + 8'd1;
        rsp.stack_addr = {STACK_PAGE, sp_d};
        p_d            = opnd;
        p_d[FLAG_B]    = 1'b0;
      end
      OP_BRT: rsp.branch_taken = opnd[0] ? cond_bit : !cond_bit;
      default: ;
    endcase
    if (nz_upd) begin
      p_d[FLAG_Z] = (nz_val == 8'd0);
      p_d[FLAG_N] = nz_val[7];
    end
    rsp.status = p_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      a_q        <= 8'd0;
      x_q        <= 8'd0;
      y_q        <= 8'd0;
      sp_q       <= SP_RESET;
      p_q        <= 8'd0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s1_fire) begin
        a_q  <= a_d;
        x_q  <= x_d;
        y_q  <= y_d;
        sp_q <= sp_d;
        p_q  <= p_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_q <= in_data_i;
    end
    if (s1_fire) begin
      s2_q <= rsp;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_q;

`include "cpu_6502_execute_unit_macros.svh"

  `CPU6502_ASSERT(a_state_holds_idle, !s1_fire |=> ($stable(a_q) && $stable(sp_q) && $stable(p_q)), "architectural state changed without a transfer")
  `CPU6502_ASSERT(a_push_decrements_sp, (s1_fire && (op == OP_PHA || op == OP_PHP)) |=> (sp_q == $past(sp_q) - 8'd1), "push did not decrement the stack pointer")
  `CPU6502_NEVER(a_write_and_branch, out_valid_o && out_data_o.write_enable && out_data_o.branch_taken, "write strobe together with taken branch")
  `CPU6502_NEVER(a_stall_when_empty, !s1_valid_q && in_stall_o, "input stalled with an empty input register")

endmodule

// ===== tb/tb_top.sv =====
// testbench for the 6502 execute unit: directed table then random ops, scoreboarded
`timescale 1ns / 1ps

module tb_top;
  import cpu6502_pkg::*;

  localparam logic [5:0] OP_UNUSED_TOP = 6'd63;
  localparam logic [1:0] SH_ASL = 2'd0;
  localparam logic [1:0] SH_ROL = 2'd1;
  localparam logic [1:0] SH_LSR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  localparam int unsigned RANDOM_OPS = 750;
  localparam int unsigned LONG_HOLD_AT = 300;
  localparam int unsigned LONG_HOLD_CYCLES = 60;
  localparam int unsigned DRAIN_AT = 520;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam rsp_t NO_RSP = '0;

  typedef struct packed {
    req_t req;
    logic known;
    rsp_t want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_data_o;

  logic [7:0] pred_a = 8'h00;
  logic [7:0] pred_x = 8'h00;
  logic [7:0] pred_y = 8'h00;
  logic [7:0] pred_sp = SP_RESET;
  logic [7:0] pred_p = 8'h00;

  rsp_t pending_rsp[$];
  int unsigned fail_count = 0;
  int unsigned results_seen = 0;
  int unsigned sent_count = 0;
  int unsigned quiet_left = 0;
  bit long_hold_done = 1'b0;

  dir_row_t dir_rows[$] = '{
    '{'{OP_STA, 8'h00}, 1'b1, '{8'h00, 1'b1, 9'h1fd, 1'b0, 8'h00}},
    '{'{OP_PHP, 8'h00}, 1'b1, '{8'h00, 1'b1, 9'h1fd, 1'b0, 8'h00}},
    '{'{OP_LDA, 8'hff}, 1'b1, '{8'h00, 1'b0, 9'h1fc, 1'b0, 8'h80}},
    '{'{OP_ADC, 8'h01}, 1'b1, '{8'h00, 1'b0, 9'h1fc, 1'b0, 8'h03}},
    '{'{OP_SBC, 8'hff}, 1'b0, NO_RSP},
    '{'{OP_LDA, 8'h80}, 1'b0, NO_RSP},
    '{'{OP_SBC, 8'h01}, 1'b0, NO_RSP},
    '{'{OP_ADC, 8'h7f}, 1'b0, NO_RSP},
    '{'{OP_CMP, 8'h80}, 1'b0, NO_RSP},
    '{'{OP_CPX, 8'hff}, 1'b0, NO_RSP},
    '{'{OP_CPY, 8'h00}, 1'b0, NO_RSP},
    '{'{OP_BIT, 8'hff}, 1'b0, NO_RSP},
    '{'{OP_ROR_M, 8'h01}, 1'b0, NO_RSP},
    '{'{OP_ROL_A, 8'h00}, 1'b0, NO_RSP},
    '{'{OP_LSR_M, 8'hff}, 1'b0, NO_RSP},
    '{'{OP_INC_M, 8'hff}, 1'b0, NO_RSP},
    '{'{OP_DEC_M, 8'h00}, 1'b0, NO_RSP},
    '{'{OP_LDX, 8'h00}, 1'b0, NO_RSP},
    '{'{OP_TXS, 8'h00}, 1'b0, NO_RSP},
    '{'{OP_PHA, 8'h00}, 1'b0, NO_RSP},
    '{'{OP_PLP, 8'hff}, 1'b1, '{8'h00, 1'b0, 9'h100, 1'b0, 8'hef}},
    '{'{OP_TSX, 8'h00}, 1'b0, NO_RSP},
    '{'{OP_PLA, 8'h80}, 1'b0, NO_RSP},
    '{'{OP_BRT, 8'hf8}, 1'b0, NO_RSP},
    '{'{OP_BRT, 8'hff}, 1'b0, NO_RSP},
    '{'{OP_DEY, 8'h00}, 1'b0, NO_RSP},
    '{'{OP_STY, 8'h00}, 1'b0, NO_RSP},
    '{'{OP_SEC, 8'h00}, 1'b0, NO_RSP},
    '{'{OP_CLV, 8'h00}, 1'b0, NO_RSP},
    '{'{OP_CLD, 8'h00}, 1'b0, NO_RSP},
    '{'{OP_CLI, 8'h00}, 1'b0, NO_RSP},
    '{'{OP_NOP, 8'h00}, 1'b0, NO_RSP},
    '{'{OP_UNUSED_TOP, 8'hff}, 1'b0, NO_RSP}
  };

  cpu_6502_execute_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [7:0] nz_of(input logic [7:0] v);
    pred_p[FLAG_Z] = (v == 8'h00);
    pred_p[FLAG_N] = v[7];
    return v;
  endfunction

  function automatic logic [7:0] add_bytes(input logic [7:0] a, input logic [7:0] b,
                                           input logic cin, input bit with_v);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b} + {8'd0, cin};
    pred_p[FLAG_C] = s[8];
    if (with_v) begin
      pred_p[FLAG_V] = (a[7] ^ s[7]) & (b[7] ^ s[7]);
    end
    return nz_of(s[7:0]);
  endfunction

  function automatic logic [7:0] shift_byte(input logic [1:0] kind, input logic [7:0] v);
    logic ci;
    logic [7:0] r;
    ci = pred_p[FLAG_C];
    case (kind)
      SH_ASL: begin
        pred_p[FLAG_C] = v[7];
        r = {v[6:0], 1'b0};
      end
      SH_ROL: begin
        pred_p[FLAG_C] = v[7];
        r = {v[6:0], ci};
      end
      SH_LSR: begin
        pred_p[FLAG_C] = v[0];
        r = {1'b0, v[7:1]};
      end
      default: begin
        pred_p[FLAG_C] = v[0];
        r = {ci, v[7:1]};
      end
    endcase
    return nz_of(r);
  endfunction

  function automatic rsp_t execute_op(input req_t r);
    rsp_t res;
    logic [7:0] b;
    logic [5:0] k;
    logic cond_bit;
    b = r.operand;
    res = '0;
    res.stack_addr = {STACK_PAGE, pred_sp};
    case (r.req_type)
      OP_ORA: pred_a = nz_of(pred_a | b);
      OP_AND: pred_a = nz_of(pred_a & b);
      OP_EOR: pred_a = nz_of(pred_a ^ b);
      OP_ADC: pred_a = add_bytes(pred_a, b, pred_p[FLAG_C], 1'b1);
      OP_SBC: pred_a = add_bytes(pred_a, ~b, pred_p[FLAG_C], 1'b1);
      OP_CMP: void'(add_bytes(pred_a, ~b, 1'b1, 1'b0));
      OP_CPX: void'(add_bytes(pred_x, ~b, 1'b1, 1'b0));
      OP_CPY: void'(add_bytes(pred_y, ~b, 1'b1, 1'b0));
      OP_LDA: pred_a = nz_of(b);
      OP_LDX: pred_x = nz_of(b);
      OP_LDY: pred_y = nz_of(b);
      OP_STA, OP_STX, OP_STY: begin
        res.out_byte = (r.req_type == OP_STA) ? pred_a :
                       (r.req_type == OP_STX) ? pred_x : pred_y;
        res.write_enable = 1'b1;
      end
      OP_BIT: begin
        pred_p[FLAG_Z] = ((pred_a & b) == 8'h00);
        pred_p[FLAG_V] = b[6];
        pred_p[FLAG_N] = b[7];
      end
      OP_ASL_A, OP_ROL_A, OP_LSR_A, OP_ROR_A: begin
        k = r.req_type - OP_ASL_A;
        pred_a = shift_byte(k[1:0], pred_a);
      end
      OP_ASL_M, OP_ROL_M, OP_LSR_M, OP_ROR_M: begin
        k = r.req_type - OP_ASL_M;
        res.out_byte = shift_byte(k[1:0], b);
        res.write_enable = 1'b1;
      end
      OP_INC_M: begin
        res.out_byte = nz_of(b + 8'd1);
        res.write_enable = 1'b1;
      end
      OP_DEC_M: begin
        res.out_byte = nz_of(b - 8'd1);
        res.write_enable = 1'b1;
      end
      OP_INX: pred_x = nz_of(pred_x + 8'd1);
      OP_INY: pred_y = nz_of(pred_y + 8'd1);
      OP_DEX: pred_x = nz_of(pred_x - 8'd1);
      OP_DEY: pred_y = nz_of(pred_y - 8'd1);
      OP_TAX: pred_x = nz_of(pred_a);
      OP_TAY: pred_y = nz_of(pred_a);
      OP_TXA: pred_a = nz_of(pred_x);
      OP_TYA: pred_a = nz_of(pred_y);
      OP_TSX: pred_x = nz_of(pred_sp);
      OP_TXS: begin
        pred_sp = pred_x;
        res.stack_addr = {STACK_PAGE, pred_sp};
      end
      OP_CLC: pred_p[FLAG_C] = 1'b0;
      OP_SEC: pred_p[FLAG_C] = 1'b1;
      OP_CLI: pred_p[FLAG_I] = 1'b0;
      OP_SEI: pred_p[FLAG_I] = 1'b1;
      OP_CLD: pred_p[FLAG_D] = 1'b0;
      OP_SED: pred_p[FLAG_D] = 1'b1;
      OP_CLV: pred_p[FLAG_V] = 1'b0;
      OP_PHA, OP_PHP: begin
        res.out_byte = (r.req_type == OP_PHA) ? pred_a : pred_p;
        res.write_enable = 1'b1;
        res.stack_addr = {STACK_PAGE, pred_sp};
        pred_sp = pred_sp - 8'd1;
      end
      OP_PLA, OP_PLP: begin
        pred_sp = pred_sp + 8'd1;
        res.stack_addr = {STACK_PAGE, pred_sp};
        if (r.req_type == OP_PLA) begin
          pred_a = nz_of(b);
        end else begin
          pred_p = b;
          pred_p[FLAG_B] = 1'b0;
        end
      end
      OP_BRT: begin
        case (b[2:1])
          COND_N: cond_bit = pred_p[FLAG_N];
          COND_V: cond_bit = pred_p[FLAG_V];
          COND_C: cond_bit = pred_p[FLAG_C];
          default: cond_bit = pred_p[FLAG_Z];
        endcase
        res.branch_taken = b[0] ? cond_bit : ~cond_bit;
      end
      default: ;
    endcase
    res.status = pred_p;
    return res;
  endfunction

  function automatic string rsp_text(input rsp_t v);
    return $sformatf("byte %02h we %0b addr %03h br %0b st %02h",
                     v.out_byte, v.write_enable, v.stack_addr, v.branch_taken, v.status);
  endfunction

  task automatic note_failure(input string msg);
    if (fail_count < 10) begin
      $display("mismatch: %s", msg);
    end
    fail_count++;
  endtask

  task automatic check_result(input rsp_t got);
    rsp_t want;
    if (pending_rsp.size() == 0) begin
      note_failure({"unexpected transfer: ", rsp_text(got)});
      return;
    end
    want = pending_rsp.pop_front();
    if (got.out_byte !== want.out_byte || got.write_enable !== want.write_enable ||
        got.stack_addr !== want.stack_addr || got.branch_taken !== want.branch_taken ||
        got.status !== want.status) begin
      note_failure($sformatf("result %0d expected %s got %s", results_seen,
                             rsp_text(want), rsp_text(got)));
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic int unsigned next_send_gap();
    if (sent_count + 20 >= LONG_HOLD_AT && sent_count <= LONG_HOLD_AT + 60) return 0;
    if (quiet_left != 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 99) < 3) begin
      quiet_left = $urandom_range(20, 60);
      return 0;
    end
    return pick_gap();
  endfunction

  function automatic logic [7:0] pick_operand();
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 5))
        0: return 8'h00;
        1: return 8'h01;
        2: return 8'h7f;
        3: return 8'h80;
        4: return 8'hfe;
        default: return 8'hff;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic issue_req(input req_t r, input logic known, input rsp_t want);
    rsp_t pred;
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = execute_op(r);
    pending_rsp.push_back(known ? want : pred);
    sent_count++;
    gap = next_send_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      check_result(out_data_o);
      results_seen++;
    end
  end

  initial begin
    int unsigned n;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
      end else begin
        n = pick_gap();
        if (n != 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
      repeat (n) @(posedge clk_i);
    end
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    req_t r;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      issue_req(dir_rows[i].req, dir_rows[i].known, dir_rows[i].want);
    end
    for (int unsigned i = 0; i < RANDOM_OPS; i++) begin
      if (sent_count == DRAIN_AT) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (pending_rsp.size() != 0);
      end
      if ($urandom_range(0, 9) == 0) begin
        r.req_type = 6'($urandom_range(OP_NOP, OP_UNUSED_TOP));
      end else begin
        r.req_type = 6'($urandom_range(OP_ORA, OP_NOP));
      end
      r.operand = pick_operand();
      issue_req(r, 1'b0, NO_RSP);
    end
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_rsp.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
